// ===== rtl/core/ngft_pkg.sv =====
// Package for the n-gram frequency table: command codes, register indexes,
// sizes and the letter and case-fold helper functions. No dependencies.
package ngft_pkg;
  localparam int unsigned DefTableEntries = 64;
  localparam int unsigned DefCountBits    = 32;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_EOS   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  localparam logic [1:0] REG_NGRAM_LEN = 2'd0;
  localparam logic [1:0] REG_CASE_SENS = 2'd1;
  localparam logic [1:0] REG_ALPHA     = 2'd2;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] b, input logic cs);
    return (!cs && b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
  endfunction
endpackage

// ===== rtl/core/ngft_if.sv =====
// Valid/ready channel interfaces for the n-gram table.
// No dependencies.
interface ngft_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] text_byte;
  logic [5:0] entry_index;
  modport source (output valid, cmd, text_byte, entry_index, input ready);
  modport sink (input valid, cmd, text_byte, entry_index, output ready);
endinterface

interface ngft_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  first_symbol;
  logic [7:0]  second_symbol;
  logic [7:0]  third_symbol;
  logic [31:0] occurrences;
  logic        entry_present;
  logic [6:0]  entries_in_use;
  logic        table_overflowed;
  modport source (output valid, first_symbol, second_symbol, third_symbol, occurrences,
                  entry_present, entries_in_use, table_overflowed, input ready);
  modport sink (input valid, first_symbol, second_symbol, third_symbol, occurrences,
                entry_present, entries_in_use, table_overflowed, output ready);
endinterface

interface ngft_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ngft_cell.sv =====
// One table cell: holds one key and count, compares against the broadcast
// key, and swaps with its left or right neighbor. No dependencies.
module ngft_cell #(
  parameter int unsigned CountBits = 32
) (
  input  logic                 clk_i,
  input  logic                 hit_en_i,   // increment phase
  input  logic [23:0]          key_i,
  input  logic                 valid_i,    // cell below fill count
  input  logic                 append_i,   // write new key with count 1
  input  logic                 swap_en_i,  // bubble phase
  input  logic [23:0]          left_key_i,
  input  logic [CountBits-1:0] left_cnt_i,
  input  logic                 left_move_i,  // left cell swaps with this one
  input  logic [23:0]          right_key_i,
  input  logic [CountBits-1:0] right_cnt_i,
  input  logic                 right_move_i, // this cell swaps with right one
  output logic                 match_o,
  output logic                 move_o,       // this cell outranks left one
  output logic [23:0]          key_o,
  output logic [CountBits-1:0] cnt_o
);
  logic [23:0]          key_q, key_d;
  logic [CountBits-1:0] cnt_q, cnt_d;

  assign match_o = valid_i && (key_q == key_i);
  assign key_o   = key_q;
  assign cnt_o   = cnt_q;
  assign move_o  = valid_i && (left_cnt_i < cnt_q);

  always_comb begin
    key_d = key_q;
    cnt_d = cnt_q;
    if (append_i) begin
      key_d = key_i;
      cnt_d = CountBits'(1);
    end else if (hit_en_i && match_o && !(&cnt_q)) begin
      cnt_d = cnt_q + CountBits'(1);
    end else if (swap_en_i && left_move_i) begin
      key_d = left_key_i;
      cnt_d = left_cnt_i;
    end else if (swap_en_i && right_move_i) begin
      key_d = right_key_i;
      cnt_d = right_cnt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cnt_q <= cnt_d;
  end
endmodule

// ===== rtl/core/ngram_frequency_sorted_table.sv =====
// Top level of the n-gram frequency table: window, chain of cells, sequencer.
// Depends on ngft_pkg, ngft_if and ngft_cell.
//
// Usage: in_ch carries transactions of cmd/text_byte/entry_index; out_ch
// returns one result for each read command; cfg_ch writes ngram_length (0),
// the case keep mode (1) and the letters-only mode (2), which the user must
// write only while the block is idle; the block itself does not enforce it.
// Data bytes build a 2- or 3-byte window; each complete window (all letters
// in letters-only mode) is a key that is broadcast to every cell. A matching
// cell increments (saturating) and then bubbles toward the head one position
// per cycle while its left neighbor holds a smaller count; no match appends
// at the fill count, or sets the sticky overflow flag when full.
// Steps: a byte that completes no window is only accepted; a new key or an
// overflow is accepted, then counted; a hit is accepted, counted, then
// bubbled until a check finds no move, so the bubble loop across the cell
// chain sets the worst case. End of stream and clear are only accepted.
// A read lands in an output register, valid the cycle after accept; new
// transactions wait until it is free, so a stalled receiver stalls input.
// Reset empties the window and the table and loads the register defaults;
// cell contents are not cleared and are never observed before written.
module ngram_frequency_sorted_table
  import ngft_pkg::*;
#(
  parameter int unsigned TableEntries = DefTableEntries,
  parameter int unsigned CountBits    = DefCountBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  ngft_in_if.sink    in_ch,
  ngft_out_if.source out_ch,
  ngft_cfg_if.sink   cfg_ch
);
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_COUNT  = 2'd1;
  localparam logic [1:0] ST_BUBBLE = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [1:0]  nlen_q;
  logic        cs_q, alpha_q;
  logic [7:0]  win0_q, win1_q;
  logic [1:0]  fill_q;
  logic [CntW-1:0] used_q, used_d;
  logic        ovf_q, ovf_d;
  logic [23:0] key_q;
  logic        out_valid_q;

  logic [TableEntries-1:0] match, move, valid_c, append, lmove, rmove;
  logic [23:0]             key_c [TableEntries];
  logic [CountBits-1:0]    cnt_c [TableEntries];

  logic in_fire, tri_n, win_ok, do_count;
  logic [7:0] s0, s1, s2;
  cmd_e cmd;

  assign cmd      = cmd_e'(in_ch.cmd);
  assign in_ch.ready  = (state_q == ST_IDLE) && !out_valid_q;
  assign cfg_ch.ready = 1'b1;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // Window key for this byte.
  assign tri_n = (nlen_q == 2'd3);
  always_comb begin
    if (tri_n) begin
      s0 = win0_q; s1 = win1_q; s2 = in_ch.text_byte;
    end else begin
      s0 = win1_q; s1 = in_ch.text_byte; s2 = 8'd0;
    end
  end
  assign win_ok = (fill_q >= (tri_n ? 2'd2 : 2'd1)) &&
    (!alpha_q || (is_letter(s0) && is_letter(s1) && (!tri_n || is_letter(s2))));
  assign do_count = in_fire && (cmd == CMD_DATA) && win_ok;

  // Cells and their neighbor links.
  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    assign valid_c[g] = (CntW'(g) < used_q);
    assign append[g]  = (state_q == ST_COUNT) && !(|match) &&
                        (CntW'(g) == used_q);
    if (g == 0) begin : g_head
      assign lmove[g] = 1'b0;
    end else begin : g_body
      assign lmove[g] = move[g];
    end
    if (g == TableEntries - 1) begin : g_tail
      assign rmove[g] = 1'b0;
    end else begin : g_mid
      assign rmove[g] = lmove[g+1];
    end
    ngft_cell #(.CountBits(CountBits)) u_cell (
      .clk_i,
      .hit_en_i    (state_q == ST_COUNT),
      .key_i       (key_q),
      .valid_i     (valid_c[g]),
      .append_i    (append[g]),
      .swap_en_i   (state_q == ST_BUBBLE),
      .left_key_i  ((g == 0) ? key_c[0] : key_c[(g == 0) ? 0 : g-1]),
      .left_cnt_i  ((g == 0) ? {CountBits{1'b1}} : cnt_c[(g == 0) ? 0 : g-1]),
      .left_move_i (lmove[g]),
      .right_key_i (key_c[(g == TableEntries-1) ? g : g+1]),
      .right_cnt_i (cnt_c[(g == TableEntries-1) ? g : g+1]),
      .right_move_i(rmove[g]),
      .match_o     (match[g]),
      .move_o      (move[g]),
      .key_o       (key_c[g]),
      .cnt_o       (cnt_c[g])
    );
  end

  // Sequencer: idle, count, then bubble until no cell outranks its left.
  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (do_count) state_d = ST_COUNT;
        if (in_fire && cmd == CMD_CLEAR) begin
          used_d = '0;
          ovf_d  = 1'b0;
        end
      end
      ST_COUNT: begin
        if (|match) begin
          state_d = ST_BUBBLE;
        end else begin
          state_d = ST_IDLE;
          if (used_q == CntW'(TableEntries)) ovf_d = 1'b1;
          else used_d = used_q + CntW'(1);
        end
      end
      ST_BUBBLE: begin
        if (!(|lmove)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      ovf_q   <= 1'b0;
      win0_q  <= 8'd0;
      win1_q  <= 8'd0;
      fill_q  <= 2'd0;
      nlen_q  <= 2'd2;
      cs_q    <= 1'b1;
      alpha_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      ovf_q   <= ovf_d;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_NGRAM_LEN: nlen_q  <= cfg_ch.data[1:0];
          REG_CASE_SENS: cs_q    <= cfg_ch.data[0];
          REG_ALPHA:     alpha_q <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_fire && cmd == CMD_DATA) begin
        win0_q <= win1_q;
        win1_q <= in_ch.text_byte;
        if (fill_q != 2'd2) fill_q <= fill_q + 2'd1;
      end else if (in_fire && cmd == CMD_EOS) begin
        win0_q <= 8'd0;
        win1_q <= 8'd0;
        fill_q <= 2'd0;
      end
      if (in_fire && cmd == CMD_READ) out_valid_q <= 1'b1;
      else if (out_ch.ready) out_valid_q <= 1'b0;
    end
  end

  // Key register: hold the folded window for the count cycle.
  always_ff @(posedge clk_i) begin
    if (do_count) key_q <= {fold(s0, cs_q), fold(s1, cs_q), tri_n ? fold(s2, cs_q) : 8'd0};
  end

  // Read result register.
  logic [IdxW-1:0] ridx;
  logic            rpres;
  logic [23:0]     rkey_q;
  logic [31:0]     rcnt_q;
  logic            rpres_q;
  assign ridx  = IdxW'(in_ch.entry_index);
  assign rpres = (32'(in_ch.entry_index) < 32'(used_q)) &&
                 (32'(in_ch.entry_index) < 32'(TableEntries));
  always_ff @(posedge clk_i) begin
    if (in_fire && cmd == CMD_READ) begin
      rpres_q <= rpres;
      rkey_q  <= rpres ? key_c[ridx] : 24'd0;
      rcnt_q  <= rpres ? 32'(cnt_c[ridx]) : 32'd0;
    end
  end

  assign out_ch.valid            = out_valid_q;
  assign out_ch.first_symbol     = rkey_q[23:16];
  assign out_ch.second_symbol    = rkey_q[15:8];
  assign out_ch.third_symbol     = rkey_q[7:0];
  assign out_ch.occurrences      = rcnt_q;
  assign out_ch.entry_present    = rpres_q;
  assign out_ch.entries_in_use   = 7'(used_q);
  assign out_ch.table_overflowed = ovf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(match))
    else $error("key stored twice");
  assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= CntW'(TableEntries))
    else $error("fill count beyond table");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COUNT |=> state_q != ST_COUNT)
    else $error("count phase repeated");
endmodule
